// File: hdl/rbs_pkg.sv
// shared types and constants for the ray / box slab intersection pipeline
// used by rbs_div and ray_box_slab_intersection; no dependencies
package rbs_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W;
    localparam int NUM_W      = MAG_W + FRAC_BITS;
    localparam int DEN_W      = COORD_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;
    localparam int Q_W        = NUM_W + 2;
    localparam int T_W        = 31;
    localparam int AXES       = 3;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] T_SAT = Q_W'({T_W{1'b1}});

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] work;
    } div_state_t;

    typedef struct packed {
        logic [AXES-1:0] outside;
        logic [AXES-1:0] still;
    } meta_t;

endpackage

// File: hdl/rbs_div.sv
// pipelined unsigned restoring divider, DIV_BITS quotient bits per stage
// depends on rbs_pkg
module rbs_div
    import rbs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    output logic [NUM_W-1:0] q,
    output logic             q_neg
);

    function automatic div_state_t div_step(div_state_t st, logic [DEN_W-1:0] d);
        div_state_t      s;
        logic [DEN_W:0]  r;
        s = st;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r = {s.rem, s.work[NUM_W-1]};
            s.work = {s.work[NUM_W-2:0], 1'b0};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                s.work[0] = 1'b1;
            end
            s.rem = r[DEN_W-1:0];
        end
        return s;
    endfunction

    div_state_t       st_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic             neg_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        div_state_t       st_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_in;
        if (s == 0)
        begin : g_first
            assign st_in  = '{rem: '0, work: num};
            assign den_in = den;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign st_in  = st_reg[s-1];
            assign den_in = den_reg[s-1];
            assign neg_in = neg_reg[s-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s]  <= div_step(st_in, den_in);
                den_reg[s] <= den_in;
                neg_reg[s] <= neg_in;
            end
        end
    end

    assign q     = st_reg[DIV_STAGES-1].work;
    assign q_neg = neg_reg[DIV_STAGES-1];

endmodule

// File: hdl/ray_box_slab_intersection.sv
// top level of the ray / axis-aligned box slab test pipeline
// depends on rbs_pkg and rbs_div
//
// Accepts one ray / box transaction per cycle unless the output stalls and returns one
// result per transaction, in order, through stage 1, stage 2, the divider stages, f1,
// f2, f3 and the output register. The dividers are six pipelined rbs_div instances, which
// produce two quotient bits per stage. A stall on the output freezes the whole pipeline
// and is reflected on in_stall in the same cycle.
module ray_box_slab_intersection
    import rbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic signed [COORD_W-1:0] origin_z,
    input  logic signed [COORD_W-1:0] dir_x,
    input  logic signed [COORD_W-1:0] dir_y,
    input  logic signed [COORD_W-1:0] dir_z,
    input  logic signed [COORD_W-1:0] box_min_x,
    input  logic signed [COORD_W-1:0] box_min_y,
    input  logic signed [COORD_W-1:0] box_min_z,
    input  logic signed [COORD_W-1:0] box_max_x,
    input  logic signed [COORD_W-1:0] box_max_y,
    input  logic signed [COORD_W-1:0] box_max_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic [T_W-1:0]            entry_t
);

    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic signed [COORD_W-1:0] o [AXES];
    logic signed [COORD_W-1:0] d [AXES];
    logic signed [COORD_W-1:0] bl [AXES];
    logic signed [COORD_W-1:0] bh [AXES];
    assign o  = '{origin_x, origin_y, origin_z};
    assign d  = '{dir_x, dir_y, dir_z};
    assign bl = '{box_min_x, box_min_y, box_min_z};
    assign bh = '{box_max_x, box_max_y, box_max_z};

    // stage 1: slab differences, outside flags and still flags
    logic signed [DIFF_W-1:0] dlo_reg [AXES];
    logic signed [DIFF_W-1:0] dhi_reg [AXES];
    logic signed [COORD_W-1:0] dir_reg [AXES];
    meta_t meta1_reg;
    logic  v1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                dlo_reg[i] <= DIFF_W'(bl[i]) - DIFF_W'(o[i]);
                dhi_reg[i] <= DIFF_W'(bh[i]) - DIFF_W'(o[i]);
                dir_reg[i] <= d[i];
                meta1_reg.outside[i] <= (o[i] < bl[i]) || (o[i] > bh[i]);
                meta1_reg.still[i]   <= (d[i] == '0);
            end
        end
    end

    // stage 2: magnitudes and quotient signs for the dividers
    logic [NUM_W-1:0] nlo_reg [AXES];
    logic [NUM_W-1:0] nhi_reg [AXES];
    logic [DEN_W-1:0] den_reg [AXES];
    logic             slo_reg [AXES];
    logic             shi_reg [AXES];
    meta_t meta2_reg;
    logic  v2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                logic [DIFF_W-1:0] alo;
                logic [DIFF_W-1:0] ahi;
                logic [COORD_W:0]  ad;
                alo = dlo_reg[i][DIFF_W-1] ? DIFF_W'(-dlo_reg[i]) : DIFF_W'(dlo_reg[i]);
                ahi = dhi_reg[i][DIFF_W-1] ? DIFF_W'(-dhi_reg[i]) : DIFF_W'(dhi_reg[i]);
                ad  = dir_reg[i][COORD_W-1] ? -{dir_reg[i][COORD_W-1], dir_reg[i]}
                                            : {1'b0, dir_reg[i]};
                nlo_reg[i] <= {alo[MAG_W-1:0], {FRAC_BITS{1'b0}}};
                nhi_reg[i] <= {ahi[MAG_W-1:0], {FRAC_BITS{1'b0}}};
                den_reg[i] <= ad[DEN_W-1:0];
                slo_reg[i] <= dlo_reg[i][DIFF_W-1] ^ dir_reg[i][COORD_W-1];
                shi_reg[i] <= dhi_reg[i][DIFF_W-1] ^ dir_reg[i][COORD_W-1];
            end
            meta2_reg <= meta1_reg;
        end
    end

    logic [NUM_W-1:0] qlo [AXES];
    logic [NUM_W-1:0] qhi [AXES];
    logic             nglo [AXES];
    logic             nghi [AXES];

    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        rbs_div u_div_lo (
            .clk   (clk),
            .en    (adv),
            .num   (nlo_reg[i]),
            .den   (den_reg[i]),
            .neg   (slo_reg[i]),
            .q     (qlo[i]),
            .q_neg (nglo[i])
        );
        rbs_div u_div_hi (
            .clk   (clk),
            .en    (adv),
            .num   (nhi_reg[i]),
            .den   (den_reg[i]),
            .neg   (shi_reg[i]),
            .q     (qhi[i]),
            .q_neg (nghi[i])
        );
    end

    // metadata and valid bits ride alongside the divider stages
    meta_t meta_dly_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vdiv_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_dly_reg[0] <= meta2_reg;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                meta_dly_reg[s] <= meta_dly_reg[s-1];
            end
        end
    end

    // f1: signed slab times
    logic signed [Q_W-1:0] ta_reg [AXES];
    logic signed [Q_W-1:0] tb_reg [AXES];
    meta_t meta_f1_reg;
    logic  vf1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                ta_reg[i] <= nglo[i] ? -$signed({2'b00, qlo[i]}) : $signed({2'b00, qlo[i]});
                tb_reg[i] <= nghi[i] ? -$signed({2'b00, qhi[i]}) : $signed({2'b00, qhi[i]});
            end
            meta_f1_reg <= meta_dly_reg[DIV_STAGES-1];
        end
    end

    // f2: order each slab pair, still axes leave the interval alone
    logic signed [Q_W-1:0] smin_reg [AXES];
    logic signed [Q_W-1:0] smax_reg [AXES];
    meta_t meta_f2_reg;
    logic  vf2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                if (meta_f1_reg.still[i])
                begin
                    smin_reg[i] <= '0;
                    smax_reg[i] <= Q_MAX;
                end
                else if (ta_reg[i] > tb_reg[i])
                begin
                    smin_reg[i] <= tb_reg[i];
                    smax_reg[i] <= ta_reg[i];
                end
                else
                begin
                    smin_reg[i] <= ta_reg[i];
                    smax_reg[i] <= tb_reg[i];
                end
            end
            meta_f2_reg <= meta_f1_reg;
        end
    end

    // f3: narrow the interval over all axes and derive the inside and still-miss flags
    logic signed [Q_W-1:0] tlo_reg;
    logic signed [Q_W-1:0] thi_reg;
    logic inside_reg;
    logic still_miss_reg;
    logic vf3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [Q_W-1:0] lo;
            logic signed [Q_W-1:0] hi;
            lo = '0;
            hi = Q_MAX;
            for (int i = 0; i < AXES; i++)
            begin
                if (smin_reg[i] > lo)
                begin
                    lo = smin_reg[i];
                end
                if (smax_reg[i] < hi)
                begin
                    hi = smax_reg[i];
                end
            end
            tlo_reg        <= lo;
            thi_reg        <= hi;
            inside_reg     <= ~|meta_f2_reg.outside;
            still_miss_reg <= |(meta_f2_reg.outside & meta_f2_reg.still);
        end
    end

    // output register
    logic           hit_reg;
    logic [T_W-1:0] entry_t_reg;
    logic           out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (inside_reg)
            begin
                hit_reg     <= 1'b1;
                entry_t_reg <= '0;
            end
            else if (!still_miss_reg && (tlo_reg <= thi_reg))
            begin
                hit_reg     <= 1'b1;
                entry_t_reg <= (tlo_reg > T_SAT) ? {T_W{1'b1}} : tlo_reg[T_W-1:0];
            end
            else
            begin
                hit_reg     <= 1'b0;
                entry_t_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vdiv_reg      <= '0;
            vf1_reg       <= 1'b0;
            vf2_reg       <= 1'b0;
            vf3_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            vdiv_reg      <= {vdiv_reg[DIV_STAGES-2:0], v2_reg};
            vf1_reg       <= vdiv_reg[DIV_STAGES-1];
            vf2_reg       <= vf1_reg;
            vf3_reg       <= vf2_reg;
            out_valid_reg <= vf3_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign entry_t   = entry_t_reg;

`ifndef SYNTHESIS
    a_miss_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> entry_t == '0)
        else $error("miss with nonzero entry_t");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transaction lost at pipeline entry");
`endif

endmodule
